FILE: rtl/nifl_pkg.sv
// Package for the node index free-list allocator.
// Field widths, status and command codes, and the control state type.
// No dependencies.
package nifl_pkg;

  localparam int IDX_W         = 10;
  localparam int STAT_W        = 2;
  localparam int NODES_DEFAULT = 1024;
  localparam int S_TDATA_W     = 16;
  localparam int M_TDATA_W     = 24;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

endpackage

FILE: rtl/nifl_link_mem.sv
// Link memory of the free list: one write port, one read port, registered read.
// Depends on nifl_pkg.
module nifl_link_mem #(
  parameter int NODES = nifl_pkg::NODES_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       re_i,
  input  logic [$clog2(NODES)-1:0]   raddr_i,
  output logic [nifl_pkg::IDX_W-1:0] rdata_o,
  input  logic                       we_i,
  input  logic [$clog2(NODES)-1:0]   waddr_i,
  input  logic [nifl_pkg::IDX_W-1:0] wdata_i
);

  logic [nifl_pkg::IDX_W-1:0] mem [NODES];
  logic [nifl_pkg::IDX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/node_index_free_list_allocator.sv
// Node index allocator: free list linked through a link memory, top-index bump.
// Result registered in S_EXEC when the output is free; held while m_axis_tready is low.
// One request at a time: a new one is taken only after the link memory read and update.
// Reset: head 0, top 1, count 0, output empty; the link memory is not cleared.
// Depends on nifl_pkg and nifl_link_mem.
module node_index_free_list_allocator #(
  parameter int NODES = nifl_pkg::NODES_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [nifl_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [9:0] index_to_free
  input  logic                             s_axis_tuser,  // [0] cmd
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [nifl_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // [9:0] granted_index,
                                                          // [19:10] active_count
  output logic [nifl_pkg::STAT_W-1:0]      m_axis_tuser   // [1:0] status
);

  localparam int IW = nifl_pkg::IDX_W;
  localparam int AW = $clog2(NODES);
  localparam int CW = (AW + 1 > IW + 1) ? AW + 1 : IW + 1;

  nifl_pkg::state_e  state_q, state_d;
  nifl_pkg::cmd_e    cmd_q;
  logic [IW-1:0]     idx_q;
  logic [IW-1:0]     head_q, head_d;
  logic [IW-1:0]     top_q, top_d;
  logic [IW-1:0]     count_q, count_d;

  logic              m_valid_q;
  logic [IW-1:0]     gidx_q, gidx_d;
  nifl_pkg::status_e status_q, status_d;
  logic [IW-1:0]     ocount_q;

  logic              accept, out_free, go;
  logic [CW-1:0]     top_inc;
  logic [IW-1:0]     rdata;
  logic              we;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign go       = (state_q == nifl_pkg::S_EXEC) && out_free;
  assign top_inc  = CW'(top_q) + CW'(1);

  assign s_axis_tready = (state_q == nifl_pkg::S_IDLE);

  nifl_link_mem #(
    .NODES(NODES)
  ) u_link_mem (
    .clk_i  (clk_i),
    .re_i   (accept),
    .raddr_i(AW'(head_q)),
    .rdata_o(rdata),
    .we_i   (we),
    .waddr_i(AW'(idx_q)),
    .wdata_i(head_q)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nifl_pkg::S_IDLE: if (accept) state_d = nifl_pkg::S_EXEC;
      nifl_pkg::S_EXEC: if (out_free) state_d = nifl_pkg::S_IDLE;
      default:          state_d = nifl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    head_d   = head_q;
    top_d    = top_q;
    count_d  = count_q;
    gidx_d   = '0;
    status_d = nifl_pkg::ST_OK;
    we       = 1'b0;
    if (cmd_q == nifl_pkg::CMD_ALLOC) begin
      if (head_q != '0) begin
        gidx_d  = head_q;
        head_d  = rdata;
        count_d = count_q + IW'(1);
      end else if (top_inc < CW'(NODES)) begin
        top_d   = IW'(top_inc);
        gidx_d  = IW'(top_inc);
        count_d = count_q + IW'(1);
      end else begin
        status_d = nifl_pkg::ST_FULL;
      end
    end else begin
      if (idx_q < IW'(2) || idx_q > top_q) begin
        status_d = nifl_pkg::ST_BAD;
      end else begin
        if (count_q != '0) count_d = count_q - IW'(1);
        if (idx_q == top_q) begin
          top_d = top_q - IW'(1);
        end else begin
          we     = go;
          head_d = idx_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nifl_pkg::S_IDLE;
      head_q    <= '0;
      top_q     <= IW'(1);
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (go) begin
        head_q    <= head_d;
        top_q     <= top_d;
        count_q   <= count_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= nifl_pkg::cmd_e'(s_axis_tuser);
      idx_q <= s_axis_tdata[IW-1:0];
    end
    if (go) begin
      gidx_q   <= gidx_d;
      status_q <= status_d;
      ocount_q <= count_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(nifl_pkg::M_TDATA_W - 2 * IW)'(0), ocount_q, gidx_q};
  assign m_axis_tuser  = status_q;

endmodule

FILE: rtl/nifl_checker.sv
// Port-level checks for the node index allocator, bound to the top level.
// Depends on nifl_pkg and node_index_free_list_allocator.
module nifl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [nifl_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [nifl_pkg::STAT_W-1:0]    m_axis_tuser
);

  localparam int IW = nifl_pkg::IDX_W;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while previous one in flight");

  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != nifl_pkg::ST_OK |-> m_axis_tdata[IW-1:0] == '0)
    else $error("index granted on failed request");

  a_no_reserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[IW-1:0] != '0 |-> m_axis_tdata[IW-1:1] != '0)
    else $error("reserved index granted");

endmodule

bind node_index_free_list_allocator nifl_checker u_nifl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

FILE: verif/tb_top.sv
// Testbench for node_index_free_list_allocator: directed corners, random
// allocate/free traffic, churn at the top and a broken free list at the end.
// Depends on nifl_pkg and the allocator RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nifl_pkg::*;

  localparam int NODES        = NODES_DEFAULT;
  localparam int RANDOM_ITEMS = 480;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic [IDX_W-1:0] granted;
    status_e          status;
    logic [IDX_W-1:0] count;
  } alloc_result_t;

  typedef struct packed {
    cmd_e             cmd;
    logic [IDX_W-1:0] idx;
    logic             typed;
    alloc_result_t    res;
  } table_row_t;

  localparam alloc_result_t ANY = '{granted: '0, status: ST_OK, count: '0};

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = CMD_ALLOC;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]    m_axis_tuser;

  bit calm = 1'b0;

  // predictor state
  logic [IDX_W-1:0] pred_head;
  logic [IDX_W-1:0] pred_top;
  logic [IDX_W-1:0] pred_links [NODES];
  logic [IDX_W-1:0] pred_active;

  alloc_result_t    awaited_replies[$];
  logic [IDX_W-1:0] held_indices[$];
  table_row_t       opening_rows[$];
  table_row_t       closing_rows[$];

  int n_mismatch = 0;
  int n_alloc = 0, n_full = 0, n_free = 0, n_bad = 0, peak_top = 0;
  int stall_cycles = 0;

  node_index_free_list_allocator #(.NODES(NODES)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic alloc_result_t predict_alloc_step(cmd_e c, logic [IDX_W-1:0] idx);
    alloc_result_t r;
    r = ANY;
    if (c == CMD_ALLOC) begin
      if (pred_head != '0) begin
        r.granted   = pred_head;
        pred_head   = pred_links[pred_head];
        pred_active = pred_active + 1'b1;
      end else if (int'(pred_top) + 1 < NODES) begin
        pred_top    = pred_top + 1'b1;
        r.granted   = pred_top;
        pred_active = pred_active + 1'b1;
      end else begin
        r.status = ST_FULL;
      end
    end else if (idx < 2 || idx > pred_top) begin
      r.status = ST_BAD;
    end else begin
      if (pred_active != '0) pred_active = pred_active - 1'b1;
      if (idx == pred_top) begin
        pred_top = pred_top - 1'b1;
      end else begin
        pred_links[idx] = pred_head;
        pred_head       = idx;
      end
    end
    r.count = pred_active;
    return r;
  endfunction

  // A push of an index already on the list below top would close a loop in it.
  function automatic bit on_list_below_top(logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] walk;
    walk = pred_head;
    if (idx < 2 || idx >= pred_top) return 1'b0;
    for (int n = 0; n < NODES && walk != '0; n++) begin
      if (walk == idx) return 1'b1;
      walk = pred_links[walk];
    end
    return 1'b0;
  endfunction

  task automatic send_request(input cmd_e c, input logic [IDX_W-1:0] idx, input logic typed,
                              input alloc_result_t typed_res, output alloc_result_t got);
    if (!calm && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W-IDX_W){1'b0}}, idx};
    s_axis_tuser  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    got = predict_alloc_step(c, idx);
    awaited_replies.push_back(typed ? typed_res : got);
    if (c == CMD_ALLOC) begin
      n_alloc++;
      if (got.status == ST_FULL) n_full++;
      else held_indices.push_back(got.granted);
    end else begin
      n_free++;
      if (got.status == ST_BAD) begin
        n_bad++;
      end else begin
        for (int k = 0; k < held_indices.size(); k++) begin
          if (held_indices[k] == idx) begin
            held_indices.delete(k);
            break;
          end
        end
      end
    end
    if (int'(pred_top) > peak_top) peak_top = pred_top;
  endtask

  task automatic run_rows(input table_row_t rows[$]);
    alloc_result_t got;
    foreach (rows[i]) send_request(rows[i].cmd, rows[i].idx, rows[i].typed, rows[i].res, got);
  endtask

  task automatic send_random_free(output alloc_result_t got);
    logic [IDX_W-1:0] idx;
    idx = $urandom_range(0, NODES - 1);
    if (held_indices.size() > 0) idx = held_indices[$urandom_range(0, held_indices.size() - 1)];
    if (on_list_below_top(idx)) idx = '0;
    send_request(CMD_FREE, idx, 1'b0, ANY, got);
  endtask

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk_i) begin : reply_check
    alloc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("reply count (none pending)", 0, 1);
      end else begin
        want = awaited_replies.pop_front();
        if (m_axis_tdata[IDX_W-1:0] != want.granted)
          report_mismatch("granted_index", want.granted, m_axis_tdata[IDX_W-1:0]);
        if (m_axis_tuser != want.status)
          report_mismatch("status", want.status, m_axis_tuser);
        if (m_axis_tdata[2*IDX_W-1:IDX_W] != want.count)
          report_mismatch("active_count", want.count, m_axis_tdata[2*IDX_W-1:IDX_W]);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    alloc_result_t    got;
    logic [IDX_W-1:0] idx;
    int               pick;

    pred_head   = '0;
    pred_top    = 10'd1;
    pred_active = '0;

    // reserved, above-top, fresh grants, push vs. top-lowering frees,
    // count saturation, top freed while on the list, ignored field on allocate
    opening_rows.push_back('{CMD_FREE,  10'd0,    1'b1, '{10'd0, ST_BAD, 10'd0}});
    opening_rows.push_back('{CMD_FREE,  10'd1,    1'b1, '{10'd0, ST_BAD, 10'd0}});
    opening_rows.push_back('{CMD_FREE,  10'd1023, 1'b1, '{10'd0, ST_BAD, 10'd0}});
    opening_rows.push_back('{CMD_ALLOC, 10'd0,    1'b1, '{10'd2, ST_OK,  10'd1}});
    opening_rows.push_back('{CMD_ALLOC, 10'd0,    1'b1, '{10'd3, ST_OK,  10'd2}});
    opening_rows.push_back('{CMD_ALLOC, 10'd0,    1'b1, '{10'd4, ST_OK,  10'd3}});
    opening_rows.push_back('{CMD_FREE,  10'd3,    1'b0, ANY});
    opening_rows.push_back('{CMD_FREE,  10'd4,    1'b0, ANY});
    opening_rows.push_back('{CMD_ALLOC, 10'd0,    1'b0, ANY});
    opening_rows.push_back('{CMD_FREE,  10'd2,    1'b0, ANY});
    opening_rows.push_back('{CMD_FREE,  10'd3,    1'b0, ANY});
    opening_rows.push_back('{CMD_FREE,  10'd2,    1'b0, ANY});
    opening_rows.push_back('{CMD_ALLOC, 10'd0,    1'b0, ANY});
    opening_rows.push_back('{CMD_ALLOC, 10'd0,    1'b0, ANY});
    opening_rows.push_back('{CMD_FREE,  10'd2,    1'b0, ANY});
    opening_rows.push_back('{CMD_FREE,  10'd2,    1'b0, ANY});
    opening_rows.push_back('{CMD_FREE,  10'd512,  1'b0, ANY});
    opening_rows.push_back('{CMD_ALLOC, 10'd0,    1'b0, ANY});
    opening_rows.push_back('{CMD_ALLOC, 10'd1023, 1'b0, ANY});

    // double free closes a loop in the list; kept for last since it is permanent
    closing_rows.push_back('{CMD_FREE,  10'd20,   1'b0, ANY});
    closing_rows.push_back('{CMD_FREE,  10'd20,   1'b0, ANY});
    closing_rows.push_back('{CMD_ALLOC, 10'd0,    1'b0, ANY});
    closing_rows.push_back('{CMD_ALLOC, 10'd0,    1'b0, ANY});
    closing_rows.push_back('{CMD_ALLOC, 10'd0,    1'b0, ANY});
    closing_rows.push_back('{CMD_FREE,  10'd1023, 1'b0, ANY});
    closing_rows.push_back('{CMD_ALLOC, 10'd0,    1'b0, ANY});
    closing_rows.push_back('{CMD_FREE,  10'd0,    1'b0, ANY});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_rows(opening_rows);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= 200 && n < 300);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_request(CMD_ALLOC, IDX_W'($urandom_range(0, NODES - 1)), 1'b0, ANY, got);
      end else if (pick < 85) begin
        send_random_free(got);
      end else begin
        case ($urandom_range(0, 3))
          0: idx = IDX_W'($urandom_range(0, 1));
          1: idx = IDX_W'($urandom_range(0, NODES - 1));
          2: idx = (pred_top > 10'd1019) ? 10'd1023 : pred_top + IDX_W'($urandom_range(1, 4));
          default: idx = pred_top;
        endcase
        if (on_list_below_top(idx)) idx = '0;
        send_request(CMD_FREE, idx, 1'b0, ANY, got);
      end
    end

    // churn at the top
    send_request(CMD_FREE, 10'd1023, 1'b0, ANY, got);
    send_request(CMD_ALLOC, 10'd0, 1'b0, ANY, got);
    repeat (20) send_random_free(got);
    repeat (25) send_request(CMD_ALLOC, 10'd0, 1'b0, ANY, got);

    run_rows(closing_rows);

    s_axis_tvalid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d allocates (%0d full) and %0d frees (%0d rejected); peak top index %0d.",
             n_alloc, n_full, n_free, n_bad, peak_top);
    $display("Included reserved and above-top frees, top freed while listed, a looped list.");
    if (n_mismatch == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
